/* hw/rtl/pcx_rle_plane_decoder_unit_macros.svh */
`ifndef PCX_RLE_PLANE_DECODER_UNIT_MACROS_SVH
`define PCX_RLE_PLANE_DECODER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define PCXRLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PCXRLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pcxrle_pkg.sv */
`timescale 1ns / 1ps

package pcxrle_pkg;

  localparam int BYTE_W    = 8;
  localparam int OFF_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PLANES_W  = 3;
  localparam int RUN_W     = 6;

  typedef enum logic [1:0] {
    ST_PIXEL = 2'd0,
    ST_DONE  = 2'd1,
    ST_TRUNC = 2'd2
  } status_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BPP    = 2'd0,
    REG_PLANES = 2'd1,
    REG_KEPT   = 2'd2,
    REG_ROWS   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic         take;
    logic         advance;
    status_code_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic starts_place;
    logic kept;
    logic last_iter;
    logic complete;
  } dp_stat_t;

  typedef struct packed {
    logic push;
    logic close;
  } ob_cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel;
    logic [OFF_W-1:0]  offset;
    status_code_t      status;
  } result_t;

endpackage

/* hw/rtl/pcxrle_ctrl.sv */
`timescale 1ns / 1ps

module pcxrle_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               in_eos,
  input  pcxrle_pkg::dp_stat_t dstat,
  input  logic               can_push,
  output pcxrle_pkg::dp_cmd_t  dcmd,
  output pcxrle_pkg::ob_cmd_t  ocmd
);
  import pcxrle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLACE,
    S_CMPL,
    S_TRUNC,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   stall;

  assign s_tready = (state == S_IDLE) || (state == S_DONE);
  assign stall    = dstat.kept && !can_push;

  always_comb begin
    state_next   = state;
    dcmd.take    = 1'b0;
    dcmd.advance = 1'b0;
    dcmd.kind    = ST_PIXEL;
    ocmd.push    = 1'b0;
    ocmd.close   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          dcmd.take = 1'b1;
          if (in_eos) begin
            state_next = S_TRUNC;
          end else if (dstat.starts_place) begin
            state_next = S_PLACE;
          end
        end
      end
      S_PLACE: begin
        ocmd.push  = dstat.kept && can_push;
        ocmd.close = !stall && dstat.last_iter && !dstat.complete;
        if (!stall) begin
          dcmd.advance = 1'b1;
          if (dstat.complete) begin
            state_next = S_CMPL;
          end else if (dstat.last_iter) begin
            state_next = S_IDLE;
          end
        end
      end
      S_CMPL: begin
        dcmd.kind  = ST_DONE;
        ocmd.push  = can_push;
        ocmd.close = can_push;
        if (can_push) begin
          state_next = S_DONE;
        end
      end
      S_TRUNC: begin
        dcmd.kind  = ST_TRUNC;
        ocmd.push  = can_push;
        ocmd.close = can_push;
        if (can_push) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_DONE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/pcxrle_dp.sv */
`timescale 1ns / 1ps

module pcxrle_dp #(
  parameter int DIM_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcxrle_pkg::CFG_W-1:0]         cfg_data,
  input  logic [pcxrle_pkg::BYTE_W-1:0]        in_byte,
  input  logic                                 in_eos,
  input  pcxrle_pkg::dp_cmd_t                  cmd,
  output pcxrle_pkg::dp_stat_t                 stat,
  output pcxrle_pkg::result_t                  res
);
  import pcxrle_pkg::*;

  localparam int PROD_W = DIM_BITS + PLANES_W;

  logic [CFG_W-1:0]    bpp_reg;
  logic [PLANES_W-1:0] planes_reg;
  logic [CFG_W-1:0]    kept_reg;
  logic [CFG_W-1:0]    rows_reg;

  logic                run_pending;
  logic [RUN_W-1:0]    run_length;
  logic [RUN_W-1:0]    count;
  logic [BYTE_W-1:0]   byte_q;
  logic [DIM_BITS-1:0] column;
  logic [1:0]          plane;
  logic [DIM_BITS-1:0] row;
  logic [OFF_W-1:0]    row_base;

  logic [PLANES_W-1:0] planes_eff;
  logic [DIM_BITS-1:0] kept;
  logic [DIM_BITS:0]   bpp_eff;
  logic [DIM_BITS:0]   rows_eff;
  logic [DIM_BITS:0]   col_inc;
  logic [PLANES_W-1:0] plane_inc;
  logic [DIM_BITS:0]   row_inc;
  logic                col_wrap;
  logic                plane_wrap;
  logic                row_wrap;
  logic [PROD_W-1:0]   col_prod;
  logic [PROD_W-1:0]   kept_prod;
  logic [OFF_W:0]      off_sum;
  logic [OFF_W:0]      base_sum;
  logic [OFF_W-1:0]    offset;
  logic [OFF_W-1:0]    base_next;
  logic                is_prefix;

  always_comb begin
    if (planes_reg == '0) begin
      planes_eff = PLANES_W'(1);
    end else if (planes_reg > PLANES_W'(4)) begin
      planes_eff = PLANES_W'(4);
    end else begin
      planes_eff = planes_reg;
    end
  end

  assign kept     = kept_reg[DIM_BITS-1:0];
  assign bpp_eff  = (bpp_reg[DIM_BITS-1:0] == '0) ? {1'b1, {DIM_BITS{1'b0}}}
                                                 : {1'b0, bpp_reg[DIM_BITS-1:0]};
  assign rows_eff = (rows_reg[DIM_BITS-1:0] == '0) ? {1'b1, {DIM_BITS{1'b0}}}
                                                  : {1'b0, rows_reg[DIM_BITS-1:0]};

  assign col_inc    = {1'b0, column} + (DIM_BITS+1)'(1);
  assign plane_inc  = {1'b0, plane} + PLANES_W'(1);
  assign row_inc    = {1'b0, row} + (DIM_BITS+1)'(1);
  assign col_wrap   = col_inc >= bpp_eff;
  assign plane_wrap = plane_inc >= planes_eff;
  assign row_wrap   = row_inc >= rows_eff;

  assign col_prod  = {{PLANES_W{1'b0}}, column} * {{DIM_BITS{1'b0}}, planes_eff};
  assign kept_prod = {{PLANES_W{1'b0}}, kept} * {{DIM_BITS{1'b0}}, planes_eff};
  assign off_sum   = {1'b0, row_base} + (OFF_W+1)'(col_prod) + (OFF_W+1)'(plane);
  assign base_sum  = {1'b0, row_base} + (OFF_W+1)'(kept_prod);
  assign offset    = off_sum[OFF_W] ? '1 : off_sum[OFF_W-1:0];
  assign base_next = base_sum[OFF_W] ? '1 : base_sum[OFF_W-1:0];

  assign is_prefix = in_byte[BYTE_W-1:BYTE_W-2] == 2'b11;

  assign stat.starts_place = run_pending ? (run_length != '0) : !is_prefix;
  assign stat.kept         = {1'b0, column} < {1'b0, kept};
  assign stat.last_iter    = count == RUN_W'(1);
  assign stat.complete     = col_wrap && plane_wrap && row_wrap;

  assign res.status = cmd.kind;
  assign res.pixel  = (cmd.kind == ST_PIXEL) ? byte_q : '0;
  assign res.offset = (cmd.kind == ST_PIXEL) ? offset : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp_reg    <= CFG_W'(1);
      planes_reg <= PLANES_W'(1);
      kept_reg   <= CFG_W'(1);
      rows_reg   <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BPP:    bpp_reg    <= cfg_data;
        REG_PLANES: planes_reg <= cfg_data[PLANES_W-1:0];
        REG_KEPT:   kept_reg   <= cfg_data;
        REG_ROWS:   rows_reg   <= cfg_data;
        default:    bpp_reg    <= bpp_reg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_pending <= 1'b0;
      run_length  <= '0;
      count       <= '0;
      column      <= '0;
      plane       <= '0;
      row         <= '0;
      row_base    <= '0;
    end else begin
      if (cmd.take) begin
        if (in_eos) begin
          run_pending <= 1'b0;
        end else if (run_pending) begin
          run_pending <= 1'b0;
          count       <= run_length;
          byte_q      <= in_byte;
        end else if (is_prefix) begin
          run_pending <= 1'b1;
          run_length  <= in_byte[RUN_W-1:0];
        end else begin
          count  <= RUN_W'(1);
          byte_q <= in_byte;
        end
      end
      if (cmd.advance) begin
        count <= count - RUN_W'(1);
        if (col_wrap) begin
          column <= '0;
          if (plane_wrap) begin
            plane    <= '0;
            row_base <= base_next;
            row      <= row_wrap ? '0 : row_inc[DIM_BITS-1:0];
          end else begin
            plane <= plane_inc[1:0];
          end
        end else begin
          column <= col_inc[DIM_BITS-1:0];
        end
      end
    end
  end

endmodule

/* hw/rtl/pcxrle_obuf.sv */
`timescale 1ns / 1ps

module pcxrle_obuf (
  input  logic                  clk,
  input  logic                  rst,
  input  pcxrle_pkg::ob_cmd_t   ocmd,
  input  pcxrle_pkg::result_t   res,
  output logic                  can_push,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output pcxrle_pkg::result_t   out_res,
  output logic                  m_tlast
);
  import pcxrle_pkg::*;

  // hold keeps the newest result until it is known whether another follows
  logic    hold_v;
  logic    hold_last;
  result_t hold;
  logic    ok;

  assign ok       = !m_tvalid || m_tready;
  assign can_push = !hold_v || (!hold_last && ok);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (hold_v && hold_last && ok) begin
        out_res  <= hold;
        m_tlast  <= 1'b1;
        m_tvalid <= 1'b1;
        hold_v   <= 1'b0;
      end else if (ocmd.push && can_push) begin
        if (hold_v) begin
          out_res   <= hold;
          m_tlast   <= 1'b0;
          m_tvalid  <= 1'b1;
          hold      <= res;
          hold_last <= ocmd.close;
        end else if (ocmd.close && ok) begin
          out_res  <= res;
          m_tlast  <= 1'b1;
          m_tvalid <= 1'b1;
        end else begin
          hold      <= res;
          hold_v    <= 1'b1;
          hold_last <= ocmd.close;
        end
      end else if (ocmd.close && hold_v) begin
        hold_last <= 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/pcx_rle_plane_decoder_unit.sv */
`timescale 1ns / 1ps
// channel  dir  tdata (low bit up)                 tuser            tlast
// s_*      in   data_byte[7:0]                     end_of_stream    -
// m_*      out  pixel_value[7:0], dest_offset[31:0] status[1:0]     last_of_run
// cfg_*    in   cfg_data = register value, cfg_index = register index
//
// a literal byte is taken in a transfer, then placed; a run prefix is only taken
// a run of n bytes is taken, then its n bytes are placed, then a done status if the image completes inside it
// the position unit places one byte per cycle while no kept byte is held by a stalled output
// rst is synchronous and restores the register defaults and the scan position
// a stalled output holds the loop only when a kept byte or a status result has no slot

module pcx_rle_plane_decoder_unit #(
  parameter int DIM_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcxrle_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [7:0]                            s_tdata,  // data_byte
  input  logic                                  s_tuser,  // end_of_stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [39:0]                           m_tdata,  // pixel_value, dest_offset
  output logic [1:0]                            m_tuser,  // status
  output logic                                  m_tlast
);
  import pcxrle_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;
  ob_cmd_t  ocmd;
  result_t  res;
  result_t  out_res;
  logic     can_push;

  pcxrle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_eos   (s_tuser),
    .dstat    (dstat),
    .can_push (can_push),
    .dcmd     (dcmd),
    .ocmd     (ocmd)
  );

  pcxrle_dp #(
    .DIM_BITS (DIM_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (s_tdata),
    .in_eos    (s_tuser),
    .cmd       (dcmd),
    .stat      (dstat),
    .res       (res)
  );

  pcxrle_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .ocmd     (ocmd),
    .res      (res),
    .can_push (can_push),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .out_res  (out_res),
    .m_tlast  (m_tlast)
  );

  assign m_tdata = {out_res.offset, out_res.pixel};
  assign m_tuser = out_res.status;

endmodule

/* hw/rtl/pcxrle_chk.sv */
`timescale 1ns / 1ps
`include "pcx_rle_plane_decoder_unit_macros.svh"

module pcxrle_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import pcxrle_pkg::*;

  `PCXRLE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
  `PCXRLE_ASSERT_NOW(a_status_last, m_tvalid && (m_tuser != ST_PIXEL), m_tlast, "status result not marked last")
  `PCXRLE_ASSERT_NOW(a_status_zero, m_tvalid && (m_tuser != ST_PIXEL), m_tdata == '0, "status result carries data")
  `PCXRLE_ASSERT_NEXT(a_quiet_after_end, m_tvalid && m_tready && (m_tuser != ST_PIXEL), !m_tvalid, "result after image end")

endmodule

bind pcx_rle_plane_decoder_unit pcxrle_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
